FILE: rtl/core/steered_wheel_odometry_top_defines.svh
// Assertion macros used by the checker file of the steered wheel odometry block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef STEERED_WHEEL_ODOMETRY_TOP_DEFINES_SVH
`define STEERED_WHEEL_ODOMETRY_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/swo_pkg.sv
// Package of the steered wheel odometry block: widths, field layout, constants,
// the arctangent table, the sequencer states and angle helper functions.
// No dependencies.
`default_nettype none

package swo_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanDepth   = 32;
  localparam int unsigned AtanIdxW    = 5;

  localparam int unsigned MulAW   = 42;
  localparam int unsigned MulBW   = 34;
  localparam int unsigned MulPW   = MulAW + MulBW;
  localparam int unsigned MulCntW = $clog2(MulBW);

  localparam int unsigned DivNW   = 64;
  localparam int unsigned DivDW   = 33;
  localparam int unsigned DivCntW = $clog2(DivNW);

  localparam int unsigned CordW = 34;
  localparam int unsigned ZW    = 33;
  localparam int unsigned WrapW = 35;

  localparam int unsigned InDataW    = 80;
  localparam int unsigned OutDataW   = 136;
  localparam int unsigned OutHeadLsb = 64;
  localparam int unsigned HeadW      = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [WrapW-1:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [WrapW-1:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [WrapW-1:0] TwoPiQ30  = 35'sd6746518852;
  localparam logic signed [DivDW:0]   TwoPiDen  = 34'sd6746518852;
  localparam logic signed [CordW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [63:0]      TurnLim   = 64'sd1099511627776;
  localparam logic signed [HeadW-1:0] HeadingMax = 16'sd25736;

  localparam logic [15:0] RadiusRst  = 16'd3867;
  localparam logic [15:0] BaseRst    = 16'd1331;
  localparam logic [14:0] ThrRst     = 15'd16;
  localparam logic [15:0] RateRst    = 16'd100;
  localparam logic [31:0] StartXRst  = 32'd48575;
  localparam logic [31:0] StartYRst  = 32'd206982;
  localparam logic [15:0] StartHRst  = 16'hCDBC;

  localparam logic [31:0] AtanTable [AtanDepth] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgWheelRadius,
    CfgWheelbase,
    CfgSteerThr,
    CfgUpdateRate,
    CfgStartX,
    CfgStartY,
    CfgStartHeading
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIST,
    S_SPEED,
    S_STEER,
    S_BASE,
    S_RTDIV,
    S_DYDIV,
    S_WRAP1,
    S_CORD1,
    S_WRAP2,
    S_CORD2,
    S_TURNX,
    S_TURNY,
    S_TURNR,
    S_SWRAP,
    S_SCORD,
    S_SX,
    S_SY,
    S_HWRAP,
    S_OUT
  } swo_state_e;

  typedef struct packed {
    logic                 neg;
    logic signed [ZW-1:0] z;
  } fold_t;

  // Brings a remainder of a division by two pi into the range [-pi, pi].
  function automatic logic signed [WrapW-1:0] wrap_adjust(input logic signed [WrapW-1:0] r);
    logic signed [WrapW-1:0] res;
    res = r;
    if (r > PiQ30) begin
      res = r - TwoPiQ30;
    end else if (r < -PiQ30) begin
      res = r + TwoPiQ30;
    end
    return res;
  endfunction

  // Folds an angle in [-pi, pi] into [-pi/2, pi/2] and flags the sign flip.
  function automatic fold_t fold_angle(input logic signed [WrapW-1:0] a);
    fold_t                   res;
    logic signed [WrapW-1:0] t;
    t       = a;
    res.neg = 1'b0;
    if (a > HalfPiQ30) begin
      t       = a - PiQ30;
      res.neg = 1'b1;
    end else if (a < -HalfPiQ30) begin
      t       = a + PiQ30;
      res.neg = 1'b1;
    end
    res.z = t[ZW-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/steered_wheel_odometry_top.sv
// Top level of the steered wheel odometry block: sequencer, bit-serial multiplier,
// radix-2 divider and iterative CORDIC shared over all steps of one tick.
// Depends on swo_pkg.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata: right, left, steering; tuser: valid
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: x, y, heading, speed, turn rate
//   cfg       in         cfg_we_i                       cfg_idx_i, cfg_data_i
//
// A tick runs the multiplier, the divider (also used to wrap angles by two pi) and
// the CORDIC one after the other; a turning tick runs more steps than a straight one.
// Ticks with the valid flag low and the first valid tick finish in their accept cycle.
// A result waits in the output register while the next tick is accepted and processed.
// Reset is asynchronous and active low; it loads the register defaults.
`default_nettype none

module steered_wheel_odometry_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // right_wheel_angle [31:0], left_wheel_angle [63:32], steering_angle [79:64]
  input  logic [swo_pkg::InDataW-1:0]     s_axis_tdata,
  // data_valid [0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pos_x [31:0], pos_y [63:32], heading [79:64], linear_speed [111:80],
  // turn_rate [135:112]
  output logic [swo_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [swo_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [swo_pkg::CfgDataW-1:0]    cfg_data_i
);
  import swo_pkg::*;

  swo_state_e state_q, state_d;

  logic [15:0] radius_q, base_q, rate_q, start_h_q;
  logic [14:0] thr_q;
  logic [31:0] start_x_q, start_y_q;

  logic [31:0]        est_x_q, est_y_q, prev_r_q, prev_l_q;
  logic signed [15:0] est_h_q;
  logic               primed_q;

  logic signed [32:0]       dsum_q, dist_q;
  logic [31:0]              speed_q;
  logic signed [15:0]       st_q;
  logic signed [63:0]       yaw_q, numr_q, dy_q;
  logic signed [31:0]       rt_q;
  logic signed [CordW-1:0]  s1_q, c1_q;
  logic [23:0]              turn_q;
  logic signed [ZW-1:0]     fold_z_q;
  logic                     fold_neg_q;
  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_data_q;

  logic accept, mul_go, div_go, cord_go, out_load;

  logic [31:0]        in_right, in_left, d_right, d_left;
  logic signed [15:0] in_steer;
  logic signed [32:0] dsum_d;
  fold_t              steer_fold;
  logic signed [16:0] st_abs;
  logic               straight_now;

  assign in_right = s_axis_tdata[31:0];
  assign in_left  = s_axis_tdata[63:32];
  assign in_steer = s_axis_tdata[79:64];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign d_right  = in_right - prev_r_q;
  assign d_left   = in_left - prev_l_q;
  assign dsum_d   = $signed({d_right[31], d_right}) + $signed({d_left[31], d_left});
  assign steer_fold = fold_angle($signed({{3{in_steer[15]}}, in_steer, 16'b0}));
  assign st_abs   = st_q[15] ? -17'(st_q) : 17'(st_q);
  assign straight_now = st_abs < $signed({2'b0, thr_q});

  // Bit-serial multiplier, one multiplier bit per cycle.
  logic signed [MulAW-1:0] mul_a, mul_a_q;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulAW:0]   mul_hi_q, mul_addend, mul_sum;
  logic [MulBW-1:0]        mul_lo_q;
  logic [MulCntW-1:0]      mul_cnt_q;
  logic                    mul_busy_q, mul_done_q, mul_last;
  logic signed [MulPW-1:0] mul_prod, prod_r17, prod_r30;

  assign mul_last   = mul_cnt_q == MulCntW'(MulBW - 1);
  assign mul_addend = !mul_lo_q[0] ? '0 :
                      (mul_last ? -(MulAW+1)'(mul_a_q) : (MulAW+1)'(mul_a_q));
  assign mul_sum    = mul_hi_q + mul_addend;
  assign mul_prod   = $signed({mul_hi_q[MulAW-1:0], mul_lo_q});
  assign prod_r17   = mul_prod + MulPW'(65536);
  assign prod_r30   = mul_prod + MulPW'(536870912);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mul_done_q <= 1'b0;
      mul_cnt_q  <= '0;
    end else if (mul_done_q) begin
      mul_done_q <= 1'b0;
    end else if (mul_busy_q) begin
      mul_cnt_q <= mul_cnt_q + 1'b1;
      if (mul_last) begin
        mul_busy_q <= 1'b0;
        mul_done_q <= 1'b1;
      end
    end else if (mul_go) begin
      mul_busy_q <= 1'b1;
      mul_cnt_q  <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_busy_q) begin
      mul_hi_q <= mul_sum >>> 1;
      mul_lo_q <= {mul_sum[0], mul_lo_q[MulBW-1:1]};
    end else if (mul_go && !mul_done_q) begin
      mul_a_q  <= mul_a;
      mul_hi_q <= '0;
      mul_lo_q <= mul_b;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic signed [63:0]      div_num;
  logic signed [DivDW:0]   div_den;
  logic [DivNW-1:0]        div_n_q;
  logic [DivDW-1:0]        div_r_q, div_d_q;
  logic [DivCntW-1:0]      div_cnt_q;
  logic                    div_busy_q, div_done_q, div_qneg_q, div_rneg_q, div_last, div_ge;
  logic [DivDW:0]          div_t, div_diff;
  logic signed [DivNW:0]   div_quot;
  logic signed [WrapW-1:0] div_rem, wrapped;
  fold_t                   wrap_fold;

  assign div_last = div_cnt_q == DivCntW'(DivNW - 1);
  assign div_t    = {div_r_q, div_n_q[DivNW-1]};
  assign div_ge   = div_t >= {1'b0, div_d_q};
  assign div_diff = div_t - {1'b0, div_d_q};
  assign div_quot = div_qneg_q ? -$signed({1'b0, div_n_q}) : $signed({1'b0, div_n_q});
  assign div_rem  = div_rneg_q ? -$signed({2'b0, div_r_q}) : $signed({2'b0, div_r_q});
  assign wrapped  = wrap_adjust(div_rem);
  assign wrap_fold = fold_angle(wrapped);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_done_q) begin
      div_done_q <= 1'b0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + 1'b1;
      if (div_last) begin
        div_busy_q <= 1'b0;
        div_done_q <= 1'b1;
      end
    end else if (div_go) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_busy_q) begin
      div_r_q <= div_ge ? div_diff[DivDW-1:0] : div_t[DivDW-1:0];
      div_n_q <= {div_n_q[DivNW-2:0], div_ge};
    end else if (div_go && !div_done_q) begin
      div_n_q    <= div_num[63] ? 64'(-div_num) : 64'(div_num);
      div_d_q    <= div_den[DivDW] ? DivDW'(-div_den) : div_den[DivDW-1:0];
      div_r_q    <= '0;
      div_qneg_q <= div_num[63] ^ div_den[DivDW];
      div_rneg_q <= div_num[63];
    end
  end

  // Rotation-mode CORDIC, one iteration per cycle.
  logic signed [CordW-1:0] cx_q, cy_q, cord_shx, cord_shy, cord_s, cord_c;
  logic signed [ZW-1:0]    cz_q, cord_atan;
  logic                    cneg_q, cord_busy_q, cord_done_q, cord_last;
  logic [AtanIdxW-1:0]     ccnt_q;

  assign cord_last = ccnt_q == AtanIdxW'(CordicSteps - 1);
  assign cord_atan = $signed({1'b0, AtanTable[ccnt_q]});
  assign cord_shx  = cx_q >>> ccnt_q;
  assign cord_shy  = cy_q >>> ccnt_q;
  assign cord_s    = cneg_q ? -cy_q : cy_q;
  assign cord_c    = cneg_q ? -cx_q : cx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cord_busy_q <= 1'b0;
      cord_done_q <= 1'b0;
      ccnt_q      <= '0;
    end else if (cord_done_q) begin
      cord_done_q <= 1'b0;
    end else if (cord_busy_q) begin
      ccnt_q <= ccnt_q + 1'b1;
      if (cord_last) begin
        cord_busy_q <= 1'b0;
        cord_done_q <= 1'b1;
      end
    end else if (cord_go) begin
      cord_busy_q <= 1'b1;
      ccnt_q      <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cord_busy_q) begin
      if (!cz_q[ZW-1]) begin
        cx_q <= cx_q - cord_shy;
        cy_q <= cy_q + cord_shx;
        cz_q <= cz_q - cord_atan;
      end else begin
        cx_q <= cx_q + cord_shy;
        cy_q <= cy_q - cord_shx;
        cz_q <= cz_q + cord_atan;
      end
    end else if (cord_go && !cord_done_q) begin
      cx_q   <= GainQ30;
      cy_q   <= '0;
      cz_q   <= fold_z_q;
      cneg_q <= fold_neg_q;
    end
  end

  // Operand selection for the shared units.
  logic signed [63:0] yaw_mid, yaw_end, turn_rnd;
  logic signed [MulAW-1:0] turn_clamp;

  assign yaw_mid  = yaw_q + (dy_q >>> 1);
  assign yaw_end  = yaw_mid + dy_q;
  assign turn_rnd = (dy_q + 64'sd8192) >>> 14;
  assign turn_clamp = (turn_rnd > TurnLim) ? MulAW'(TurnLim) :
                      (turn_rnd < -TurnLim) ? MulAW'(-TurnLim) : MulAW'(turn_rnd);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DIST: begin
        mul_a = MulAW'(dsum_q);
        mul_b = $signed({18'b0, radius_q});
      end
      S_SPEED: begin
        mul_a = MulAW'(dist_q);
        mul_b = $signed({18'b0, rate_q});
      end
      S_BASE: begin
        mul_a = $signed({26'b0, base_q});
        mul_b = cord_c;
      end
      S_TURNX: begin
        mul_a = MulAW'(rt_q);
        mul_b = cord_s - s1_q;
      end
      S_TURNY: begin
        mul_a = MulAW'(rt_q);
        mul_b = c1_q - cord_c;
      end
      S_TURNR: begin
        mul_a = turn_clamp;
        mul_b = $signed({18'b0, rate_q});
      end
      S_SX: begin
        mul_a = MulAW'(dist_q);
        mul_b = cord_c;
      end
      S_SY: begin
        mul_a = MulAW'(dist_q);
        mul_b = cord_s;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_num = yaw_q;
    div_den = TwoPiDen;
    case (state_q)
      S_RTDIV: begin
        div_num = numr_q;
        div_den = cord_s;
      end
      S_DYDIV: begin
        div_num = $signed({dist_q[32], dist_q, 30'b0});
        div_den = (DivDW+1)'(rt_q);
      end
      S_WRAP1: div_num = yaw_mid;
      S_WRAP2: div_num = yaw_end;
      default: ;
    endcase
  end

  // Saturation and rounding of unit results.
  logic [31:0]        sat32, rt_sat, step_xy;
  logic [23:0]        sat24;
  logic signed [WrapW-1:0] head_rnd;

  assign sat32 = (&mul_prod[MulPW-1:31] || ~|mul_prod[MulPW-1:31]) ? mul_prod[31:0] :
                 (mul_prod[MulPW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  assign sat24 = (&mul_prod[MulPW-1:23] || ~|mul_prod[MulPW-1:23]) ? mul_prod[23:0] :
                 (mul_prod[MulPW-1] ? 24'h80_0000 : 24'h7F_FFFF);
  assign rt_sat = (&div_quot[DivNW:31] || ~|div_quot[DivNW:31]) ? div_quot[31:0] :
                  (div_quot[DivNW] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  assign step_xy  = prod_r30[61:30];
  assign head_rnd = wrapped + 35'sd65536;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept && s_axis_tuser && primed_q) state_d = S_DIST;
      S_DIST: if (mul_done_q) state_d = S_SPEED;
      S_SPEED: if (mul_done_q) state_d = straight_now ? S_SWRAP : S_STEER;
      S_STEER: if (cord_done_q) state_d = (cord_s == '0) ? S_SWRAP : S_BASE;
      S_BASE: if (mul_done_q) state_d = S_RTDIV;
      S_RTDIV: if (div_done_q) state_d = (rt_sat == '0) ? S_HWRAP : S_DYDIV;
      S_DYDIV: if (div_done_q) state_d = S_WRAP1;
      S_WRAP1: if (div_done_q) state_d = S_CORD1;
      S_CORD1: if (cord_done_q) state_d = S_WRAP2;
      S_WRAP2: if (div_done_q) state_d = S_CORD2;
      S_CORD2: if (cord_done_q) state_d = S_TURNX;
      S_TURNX: if (mul_done_q) state_d = S_TURNY;
      S_TURNY: if (mul_done_q) state_d = S_TURNR;
      S_TURNR: if (mul_done_q) state_d = S_HWRAP;
      S_SWRAP: if (div_done_q) state_d = S_SCORD;
      S_SCORD: if (cord_done_q) state_d = S_SX;
      S_SX: if (mul_done_q) state_d = S_SY;
      S_SY: if (mul_done_q) state_d = S_HWRAP;
      S_HWRAP: if (div_done_q) state_d = S_OUT;
      S_OUT: if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_go        = 1'b0;
    div_go        = 1'b0;
    cord_go       = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      S_IDLE: s_axis_tready = 1'b1;
      S_DIST, S_SPEED, S_BASE, S_TURNX, S_TURNY, S_TURNR, S_SX, S_SY: mul_go = 1'b1;
      S_RTDIV, S_DYDIV, S_WRAP1, S_WRAP2, S_SWRAP, S_HWRAP: div_go = 1'b1;
      S_STEER, S_CORD1, S_CORD2, S_SCORD: cord_go = 1'b1;
      S_OUT: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      primed_q    <= 1'b0;
      radius_q    <= RadiusRst;
      base_q      <= BaseRst;
      thr_q       <= ThrRst;
      rate_q      <= RateRst;
      start_x_q   <= StartXRst;
      start_y_q   <= StartYRst;
      start_h_q   <= StartHRst;
      est_x_q     <= StartXRst;
      est_y_q     <= StartYRst;
      est_h_q     <= $signed(StartHRst);
      prev_r_q    <= '0;
      prev_l_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CfgWheelRadius:  radius_q  <= cfg_data_i[15:0];
          CfgWheelbase:    base_q    <= cfg_data_i[15:0];
          CfgSteerThr:     thr_q     <= cfg_data_i[14:0];
          CfgUpdateRate:   rate_q    <= cfg_data_i[15:0];
          CfgStartX:       start_x_q <= cfg_data_i;
          CfgStartY:       start_y_q <= cfg_data_i;
          CfgStartHeading: start_h_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (accept && s_axis_tuser) begin
        prev_r_q <= in_right;
        prev_l_q <= in_left;
        if (!primed_q) begin
          primed_q <= 1'b1;
          est_x_q  <= start_x_q;
          est_y_q  <= start_y_q;
          est_h_q  <= $signed(start_h_q);
        end
      end
      if (mul_done_q) begin
        case (state_q)
          S_TURNX, S_SX: est_x_q <= est_x_q + step_xy;
          S_TURNY, S_SY: est_y_q <= est_y_q + step_xy;
          default: ;
        endcase
      end
      if (div_done_q && state_q == S_HWRAP) begin
        est_h_q <= head_rnd[32:17];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q       <= in_steer;
      dsum_q     <= dsum_d;
      yaw_q      <= 64'(est_h_q) <<< 17;
      turn_q     <= '0;
      fold_z_q   <= steer_fold.z;
      fold_neg_q <= steer_fold.neg;
    end
    if (mul_done_q) begin
      case (state_q)
        S_DIST:  dist_q  <= prod_r17[49:17];
        S_SPEED: speed_q <= sat32;
        S_BASE:  numr_q  <= $signed({mul_prod[59:0], 4'b0});
        S_TURNR: begin
          turn_q <= sat24;
          yaw_q  <= yaw_q + dy_q;
        end
        default: ;
      endcase
    end
    if (div_done_q) begin
      case (state_q)
        S_RTDIV: rt_q <= rt_sat;
        S_DYDIV: dy_q <= div_quot[63:0];
        S_WRAP1, S_WRAP2, S_SWRAP: begin
          fold_z_q   <= wrap_fold.z;
          fold_neg_q <= wrap_fold.neg;
        end
        default: ;
      endcase
    end
    if (cord_done_q && state_q == S_CORD1) begin
      s1_q <= cord_s;
      c1_q <= cord_c;
    end
    if (out_load) begin
      out_data_q <= {turn_q, speed_q, est_h_q, est_y_q, est_x_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/swo_checker.sv
// Port-level checker of the steered wheel odometry block and its bind statement.
// Depends on swo_pkg and steered_wheel_odometry_top_defines.svh.
`default_nettype none
`include "steered_wheel_odometry_top_defines.svh"

module swo_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         s_axis_tuser,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [swo_pkg::OutDataW-1:0] m_axis_tdata
);
  import swo_pkg::*;

  `SWO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  `SWO_ASSERT_NOW(a_heading_range, m_axis_tvalid, $signed(m_axis_tdata[OutHeadLsb +: HeadW]) <= HeadingMax && $signed(m_axis_tdata[OutHeadLsb +: HeadW]) >= -HeadingMax, "heading outside [-pi, pi]")

  `SWO_ASSERT_NEXT(a_invalid_tick_free, s_axis_tvalid && s_axis_tready && !s_axis_tuser, s_axis_tready, "tick without readings blocked the input")

  `SWO_ASSERT_NOW(a_result_after_work, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared without a tick in work")

endmodule

bind steered_wheel_odometry_top swo_checker u_swo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench of steered_wheel_odometry_top: a directed table and random
// odometry ticks under several register settings, checked by a bit-exact predictor.
// Depends on swo_pkg and steered_wheel_odometry_top.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swo_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
  localparam int unsigned NumRegs = 7;
  localparam int unsigned NumPhases = 5;
  localparam int unsigned ItemsPerPhase = 380;
  localparam int unsigned DrainCycles = 700;
  localparam int unsigned StallLimit = 20000;
  localparam longint PiQ = 64'sd3373259426;
  localparam longint HalfPiQ = 64'sd1686629713;
  localparam longint TwoPiQ = 64'sd6746518852;
  localparam longint GainQ = 64'sd652032874;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] hd;
    logic [31:0] spd;
    logic [23:0] trn;
  } pose_t;

  typedef struct {
    bit          v;
    logic [31:0] r;
    logic [31:0] l;
    logic [15:0] st;
    bit          typed;
    pose_t       want;
  } tick_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  steered_wheel_odometry_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state.
  logic [31:0] odo_reg [NumRegs];
  logic [31:0] pose_x;
  logic [31:0] pose_y;
  int          pose_head;
  logic [31:0] last_right;
  logic [31:0] last_left;
  bit          odo_primed;

  pose_t       pending_poses[$];
  int          src_idle;
  int          dst_idle;
  int          errors;
  int          n_ticks;
  int          n_poses;
  int          n_turns;
  int          stall_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_angle(input longint a);
    longint r;
    r = a % TwoPiQ;
    if (r > PiQ) r -= TwoPiQ;
    else if (r < -PiQ) r += TwoPiQ;
    return r;
  endfunction

  function automatic void rotate(input longint a, output longint s, output longint c);
    longint x, y, z, t, at;
    bit     flip;
    x = GainQ;
    y = 0;
    flip = 1'b0;
    z = wrap_angle(a);
    if (z > HalfPiQ) begin
      z -= PiQ;
      flip = 1'b1;
    end else if (z < -HalfPiQ) begin
      z += PiQ;
      flip = 1'b1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      at = longint'({32'd0, AtanTable[i]});
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= at;
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += at;
      end
      x = t;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic void load_start();
    pose_x = odo_reg[CfgStartX];
    pose_y = odo_reg[CfgStartY];
    pose_head = int'($signed(odo_reg[CfgStartHeading][15:0]));
  endfunction

  function automatic bit advance_pose(input logic [31:0] r, input logic [31:0] l,
                                      input logic [15:0] st, output pose_t p);
    longint dr, dl, travel, speed, turn, yaw, s, c, stv, thr, rate;
    longint ss, cs, rt, dy, m, s1, c1, s2, c2;
    bit     straight;
    if (!odo_primed) begin
      last_right = r;
      last_left = l;
      load_start();
      odo_primed = 1'b1;
      return 1'b0;
    end
    stv = longint'($signed(st));
    thr = longint'(odo_reg[CfgSteerThr]);
    rate = longint'(odo_reg[CfgUpdateRate]);
    turn = 0;
    dr = longint'(int'(r - last_right));
    dl = longint'(int'(l - last_left));
    last_right = r;
    last_left = l;
    travel = rnd_shift((dr + dl) * longint'(odo_reg[CfgWheelRadius]), 17);
    speed = clamp(travel * rate, -64'sd2147483648, 64'sd2147483647);
    yaw = longint'(pose_head) * 131072;
    straight = (stv < 0 ? -stv : stv) < thr;
    if (!straight) begin
      rotate(stv * 65536, ss, cs);
      if (ss == 0) begin
        straight = 1'b1;
      end else begin
        rt = clamp((longint'(odo_reg[CfgWheelbase]) * cs * 16) / ss,
                   -64'sd2147483648, 64'sd2147483647);
        if (rt != 0) begin
          dy = (travel * (64'sd1 <<< 30)) / rt;
          m = yaw + (dy >>> 1);
          rotate(m, s1, c1);
          rotate(m + dy, s2, c2);
          pose_x += 32'(rnd_shift(rt * (s2 - s1), 30));
          pose_y += 32'(rnd_shift(rt * (c1 - c2), 30));
          yaw += dy;
          turn = clamp(rnd_shift(dy, 14), -(64'sd1 <<< 40), 64'sd1 <<< 40);
          turn = clamp(turn * rate, -64'sd8388608, 64'sd8388607);
        end
      end
    end
    if (straight) begin
      rotate(yaw, s, c);
      pose_x += 32'(rnd_shift(travel * c, 30));
      pose_y += 32'(rnd_shift(travel * s, 30));
    end
    pose_head = int'(rnd_shift(wrap_angle(yaw), 17));
    p.x = pose_x;
    p.y = pose_y;
    p.hd = 16'(pose_head);
    p.spd = 32'(speed);
    p.trn = 24'(turn);
    return 1'b1;
  endfunction

  task automatic write_regs(input logic [31:0] vals[NumRegs]);
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      odo_reg[i] = i == CfgSteerThr ? {17'd0, vals[i][14:0]} :
                   (i >= CfgStartX && i <= CfgStartY) ? vals[i] : {16'd0, vals[i][15:0]};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_tick(input bit v, input logic [31:0] r, input logic [31:0] l,
                           input logic [15:0] st, input bit typed, input pose_t want);
    pose_t p;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= v;
    s_axis_tdata <= {st, l, r};
    do @(posedge clk_i); while (!s_axis_tready);
    n_ticks++;
    if (v && advance_pose(r, l, st, p)) begin
      if (p.trn != '0) n_turns++;
      pending_poses.push_back(typed ? want : p);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Result checking and the stall watchdog.
  always @(posedge clk_i) begin
    pose_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cnt = 0;
      else stall_cnt++;
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[31:0];
        got.y = m_axis_tdata[63:32];
        got.hd = m_axis_tdata[79:64];
        got.spd = m_axis_tdata[111:80];
        got.trn = m_axis_tdata[135:112];
        n_poses++;
        if (pending_poses.size() == 0) begin
          $display("%0t: expected no result, got %h", $time, got);
          errors++;
        end else begin
          want = pending_poses.pop_front();
          if (got.x !== want.x) begin
            $display("%0t: pos_x expected %h got %h", $time, want.x, got.x);
            errors++;
          end
          if (got.y !== want.y) begin
            $display("%0t: pos_y expected %h got %h", $time, want.y, got.y);
            errors++;
          end
          if (got.hd !== want.hd) begin
            $display("%0t: heading expected %h got %h", $time, want.hd, got.hd);
            errors++;
          end
          if (got.spd !== want.spd) begin
            $display("%0t: linear_speed expected %h got %h", $time, want.spd, got.spd);
            errors++;
          end
          if (got.trn !== want.trn) begin
            $display("%0t: turn_rate expected %h got %h", $time, want.trn, got.trn);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= dst_idle);
      if (stall_cnt >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    tick_row_t   rows[$];
    logic [31:0] cfg_vals[NumRegs];
    logic [31:0] r_pos, l_pos, dr, dl;
    logic [15:0] st;
    pose_t       none;
    int          item;
    bit          v;

    none = '0;
    errors = 0;
    n_ticks = 0;
    n_poses = 0;
    n_turns = 0;
    stall_cnt = 0;
    src_idle = 17;
    dst_idle = 62;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    odo_reg = '{32'(RadiusRst), 32'(BaseRst), 32'(ThrRst), 32'(RateRst),
                StartXRst, StartYRst, 32'(StartHRst)};
    load_start();
    last_right = '0;
    last_left = '0;
    odo_primed = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Start pose at the extremes, with a heading beyond pi.
    cfg_vals = '{32'(RadiusRst), 32'(BaseRst), 32'(ThrRst), 32'(RateRst),
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF};
    write_regs(cfg_vals);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgUnused;
    cfg_data_i <= 32'hFFFF_FFFF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;

    rows.push_back('{1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 16'h7FFF, 1'b0, none});
    rows.push_back('{1'b1, 32'h0, 32'h0, 16'h0, 1'b0, none});
    rows.push_back('{1'b1, 32'h0, 32'h0, 16'h0, 1'b1,
                     '{32'h7FFF_FFFF, 32'h8000_0000, 16'hB6EF, 32'h0, 24'h0}});
    rows.push_back('{1'b1, 32'h0001_0000, 32'h0001_0000, 16'h0, 1'b0, none});
    rows.push_back('{1'b1, 32'h0002_0000, 32'h0002_0000, 16'hFFF1, 1'b0, none});
    rows.push_back('{1'b1, 32'h0003_0000, 32'h0003_8000, 16'h0010, 1'b0, none});
    rows.push_back('{1'b1, 32'h0004_0000, 32'h0004_0000, 16'h7FFF, 1'b0, none});
    rows.push_back('{1'b1, 32'h0005_0000, 32'h0005_0000, 16'h8000, 1'b0, none});
    rows.push_back('{1'b1, 32'h0, 32'h0, 16'h0, 1'b0, none});
    rows.push_back('{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 1'b0, none});
    rows.push_back('{1'b1, 32'h8000_0000, 32'h8000_0000, 16'h0, 1'b0, none});
    rows.push_back('{1'b1, 32'h8000_1000, 32'h8000_1000, 16'd25736, 1'b0, none});
    rows.push_back('{1'b1, 32'h8000_2000, 32'h8000_2000, -16'sd25736, 1'b0, none});
    rows.push_back('{1'b0, 32'h1234_5678, 32'h0, 16'h4000, 1'b0, none});
    rows.push_back('{1'b1, 32'h8002_0000, 32'h8002_0000, 16'h4000, 1'b0, none});
    rows.push_back('{1'b1, 32'h8004_0000, 32'h8003_0000, 16'hC000, 1'b0, none});
    rows.push_back('{1'b1, 32'h7FFF_0000, 32'h8005_0000, 16'h2000, 1'b0, none});
    foreach (rows[i]) send_tick(rows[i].v, rows[i].r, rows[i].l, rows[i].st,
                                rows[i].typed, rows[i].want);
    r_pos = rows[rows.size() - 1].r;
    l_pos = rows[rows.size() - 1].l;
    drain();

    item = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: cfg_vals = '{32'hFFFF, 32'h1, 32'h1, 32'hFFFF, 32'h0, 32'h0, 32'h0};
        1: cfg_vals = '{32'h0, 32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h6488};
        2: cfg_vals = '{32'd3867, 32'hFFFF, 32'h7FFF, 32'd100, 32'h1, 32'h2, 32'h9B78};
        3: cfg_vals = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        default: cfg_vals = '{32'd20000, 32'd1331, 32'd200, 32'd50,
                              $urandom, $urandom, 32'h0};
      endcase
      write_regs(cfg_vals);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (item < 633) begin
          src_idle = 17;
          dst_idle = 62;
        end else if (item < 1266) begin
          src_idle = 62;
          dst_idle = 17;
        end else begin
          src_idle = 0;
          dst_idle = 0;
        end
        item++;
        v = ($urandom_range(9) != 0);
        case ($urandom_range(19))
          0, 1, 2: begin
            dr = $urandom;
            dl = $urandom;
          end
          3, 4, 5: begin
            dr = $urandom_range(32'h0006_0000) - 32'h0002_0000;
            dl = dr;
          end
          default: begin
            dr = $urandom_range(32'h0006_0000) - 32'h0002_0000;
            dl = dr + $urandom_range(32'h8000) - 32'h4000;
          end
        endcase
        case ($urandom_range(9))
          0, 1, 2, 3: st = 16'($urandom_range(128)) - 16'd64;
          4, 5, 6, 7: st = 16'($urandom_range(16'h6000)) - 16'h3000;
          default: st = 16'($urandom);
        endcase
        if (v) begin
          r_pos += dr;
          l_pos += dl;
          send_tick(1'b1, r_pos, l_pos, st, 1'b0, none);
        end else begin
          send_tick(1'b0, $urandom, $urandom, 16'($urandom), 1'b0, none);
        end
      end
      drain();
    end

    $display("Run covered %0d ticks over %0d register settings, %0d poses, %0d turning.",
             n_ticks, NumPhases + 1, n_poses, n_turns);
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending_poses.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
